FILE: rtl/mqsb_pkg.sv
`timescale 1ns / 1ps

package mqsb_pkg;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int QNUM_W = 2;
    localparam int STAT_W = 2;

    // Request codes
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // capture request, start head/tail reads
        logic look;     // decide, allocate, first memory access
        logic commit;   // link write, free list / head update
        logic load;     // move result into the output register
    } t_cmd;

endpackage

FILE: rtl/mqsb_ctrl.sv
`timescale 1ns / 1ps

module mqsb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic           i_out_free,
    output logic           o_ready,
    output mqsb_pkg::t_cmd o_cmd
);
    import mqsb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_LOOK   = 4'b0010,
        S_COMMIT = 4'b0100,
        S_HOLD   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = i_out_free ? S_IDLE : S_HOLD;
            end
            S_HOLD: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Commands; no item is taken while reset is held
    assign o_ready      = i_rst_n && (r_state == S_IDLE);
    assign o_cmd.accept = o_ready && i_valid;
    assign o_cmd.look   = (r_state == S_LOOK);
    assign o_cmd.commit = (r_state == S_COMMIT);
    assign o_cmd.load   = ((r_state == S_COMMIT) || (r_state == S_HOLD)) && i_out_free;

endmodule

FILE: rtl/mqsb_dpath.sv
`timescale 1ns / 1ps

module mqsb_dpath #(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mqsb_pkg::t_cmd                       i_cmd,
    input  logic                                 i_op,
    input  logic [mqsb_pkg::QNUM_W-1:0]          i_queue_number,
    input  logic signed [mqsb_pkg::DATA_W-1:0]   i_write_data,
    input  logic                                 i_ready,
    output logic                                 o_out_free,
    output logic                                 o_valid,
    output logic [mqsb_pkg::STAT_W-1:0]          o_status,
    output logic signed [mqsb_pkg::DATA_W-1:0]   o_read_data
);
    import mqsb_pkg::*;

    localparam int LW = $clog2(SLOTS);
    localparam int FW = $clog2(SLOTS + 1);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int XW = (QW > QNUM_W) ? QW : QNUM_W;

    // Link word: valid bit over slot number
    typedef logic [LW:0] t_link;

    // Captured request
    logic              r_op;
    logic [QNUM_W-1:0] r_q;
    logic [DATA_W-1:0] r_wdata;

    // Free list: recycled chain plus never-used region [r_fill, SLOTS)
    logic          r_free_valid;
    logic [LW-1:0] r_free_head;
    logic [FW-1:0] r_fill;

    // Per-queue state
    logic [QUEUES-1:0] r_qvalid;
    logic [LW-1:0]     r_head_mem [QUEUES];
    logic [LW-1:0]     r_tail_mem [QUEUES];
    logic [LW-1:0]     r_head_rd;
    logic [LW-1:0]     r_tail_rd;

    // Slot stores
    t_link             r_link_mem [SLOTS];
    t_link             r_link_rd;
    logic [DATA_W-1:0] r_data_mem [SLOTS];
    logic [DATA_W-1:0] r_data_rd;

    // Decision flags from the lookup cycle
    logic          r_ok;
    logic          r_was_nonempty;
    logic          r_recycled;
    logic          r_last;
    logic [LW-1:0] r_slot;

    // Output register
    logic              r_out_valid;
    logic [STAT_W-1:0] r_status;
    logic [DATA_W-1:0] r_read_data;

    // Queue indexes
    logic [XW-1:0] w_iq_ext;
    logic [XW-1:0] w_rq_ext;
    logic [QW-1:0] w_iqidx;
    logic [QW-1:0] w_qidx;
    logic          w_in_range;
    logic          w_can_alloc;
    logic [LW-1:0] w_new_slot;
    logic          w_enq_ok;
    logic          w_deq_ok;

    assign w_iq_ext    = XW'(i_queue_number);
    assign w_rq_ext    = XW'(r_q);
    assign w_iqidx     = w_iq_ext[QW-1:0];
    assign w_qidx      = w_rq_ext[QW-1:0];
    assign w_in_range  = (32'(r_q) < 32'(QUEUES));
    assign w_can_alloc = r_free_valid || (r_fill != FW'(SLOTS));
    assign w_new_slot  = r_free_valid ? r_free_head : r_fill[LW-1:0];
    assign w_enq_ok    = w_in_range && w_can_alloc;
    assign w_deq_ok    = w_in_range && r_qvalid[w_qidx];

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_q     <= i_queue_number;
            r_wdata <= i_write_data;
        end
    end

    // Lookup decision
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_ok           <= (r_op == OP_ENQ) ? w_enq_ok : w_deq_ok;
            r_was_nonempty <= r_qvalid[w_qidx];
            r_recycled     <= r_free_valid;
            r_last         <= (r_head_rd == r_tail_rd);
            r_slot         <= w_new_slot;
        end
    end

    // Head store: read at accept, written on enqueue to empty or on dequeue
    logic          w_head_we;
    logic [QW-1:0] w_head_addr;
    logic [LW-1:0] w_head_wdata;

    always_comb begin
        w_head_we    = 1'b0;
        w_head_addr  = i_cmd.accept ? w_iqidx : w_qidx;
        w_head_wdata = w_new_slot;
        if (i_cmd.look && (r_op == OP_ENQ) && w_enq_ok && !r_qvalid[w_qidx]) begin
            w_head_we = 1'b1;
        end
        if (i_cmd.commit && (r_op == OP_DEQ) && r_ok) begin
            w_head_we    = 1'b1;
            w_head_wdata = r_link_rd[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_head_we) r_head_mem[w_head_addr] <= w_head_wdata;
        if (i_cmd.accept) r_head_rd <= r_head_mem[w_head_addr];
    end

    // Tail store: read at accept, written on enqueue
    logic w_tail_we;
    assign w_tail_we = i_cmd.look && (r_op == OP_ENQ) && w_enq_ok;

    always_ff @(posedge i_clk) begin
        if (w_tail_we) r_tail_mem[w_qidx] <= w_new_slot;
        if (i_cmd.accept) r_tail_rd <= r_tail_mem[w_iqidx];
    end

    // Link store, single port: read in lookup, write in commit
    logic          w_link_we;
    logic          w_link_re;
    logic [LW-1:0] w_link_addr;
    t_link         w_link_wdata;

    always_comb begin
        w_link_we    = 1'b0;
        w_link_re    = 1'b0;
        w_link_addr  = r_head_rd;
        w_link_wdata = {r_free_valid, r_free_head};
        if (i_cmd.look) begin
            if (r_op == OP_ENQ) begin
                w_link_re   = w_enq_ok && r_free_valid;
                w_link_addr = r_free_head;
            end else begin
                w_link_re   = w_deq_ok;
                w_link_addr = r_head_rd;
            end
        end else if (i_cmd.commit && r_ok) begin
            if (r_op == OP_ENQ) begin
                w_link_we    = r_was_nonempty;
                w_link_addr  = r_tail_rd;
                w_link_wdata = {1'b1, r_slot};
            end else begin
                w_link_we    = 1'b1;
                w_link_addr  = r_head_rd;
                w_link_wdata = {r_free_valid, r_free_head};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_link_we) r_link_mem[w_link_addr] <= w_link_wdata;
        if (w_link_re) r_link_rd <= r_link_mem[w_link_addr];
    end

    // Data store, single port: write on enqueue, read on dequeue
    logic          w_data_we;
    logic          w_data_re;
    logic [LW-1:0] w_data_addr;

    assign w_data_we   = i_cmd.look && (r_op == OP_ENQ) && w_enq_ok;
    assign w_data_re   = i_cmd.look && (r_op == OP_DEQ) && w_deq_ok;
    assign w_data_addr = (r_op == OP_ENQ) ? w_new_slot : r_head_rd;

    always_ff @(posedge i_clk) begin
        if (w_data_we) r_data_mem[w_data_addr] <= r_wdata;
        if (w_data_re) r_data_rd <= r_data_mem[w_data_addr];
    end

    // Free list, fill count and queue occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_valid <= 1'b0;
            r_fill       <= '0;
            r_qvalid     <= '0;
        end else begin
            if (i_cmd.look && (r_op == OP_ENQ) && w_enq_ok) begin
                r_qvalid[w_qidx] <= 1'b1;
                if (!r_free_valid) r_fill <= r_fill + FW'(1);
            end
            if (i_cmd.commit && r_ok) begin
                if (r_op == OP_ENQ) begin
                    if (r_recycled) begin
                        r_free_valid <= r_link_rd[LW];
                        r_free_head  <= r_link_rd[LW-1:0];
                    end
                end else begin
                    r_free_valid <= 1'b1;
                    r_free_head  <= r_head_rd;
                    if (r_last) r_qvalid[w_qidx] <= 1'b0;
                end
            end
        end
    end

    // Result register
    logic [STAT_W-1:0] w_res_status;
    logic [DATA_W-1:0] w_res_data;

    always_comb begin
        if (r_op == OP_ENQ) begin
            w_res_status = r_ok ? ST_OK : ST_FULL;
            w_res_data   = '0;
        end else begin
            w_res_status = r_ok ? ST_OK : ST_EMPTY;
            w_res_data   = r_ok ? r_data_rd : '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status    <= w_res_status;
            r_read_data <= w_res_data;
        end
    end

    assign o_out_free  = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_status    = r_status;
    assign o_read_data = r_read_data;

endmodule

FILE: rtl/multi_queue_shared_buffer.sv
`timescale 1ns / 1ps
// Channel    Direction  Handshake           Payload
// request    in         i_valid / o_ready   i_op, i_queue_number, i_write_data
// result     out        o_valid / i_ready   o_status, o_read_data
//
// One request at a time: accept with head/tail read, lookup with
// the first link/data access, commit with the link write. The result is loaded
// into the output register at the end of commit, or later while the previous
// result is still held. The single-port link store is read, then written.
// Reset clears the free-list state, fill count and queue occupancy bits at once;
// no clearing pass, the first request may follow reset directly.
// A stalled result holds in the output register; the next request is accepted
// meanwhile and waits after commit only if the result has not been taken.

module multi_queue_shared_buffer #(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic                                 i_op,
    input  logic [mqsb_pkg::QNUM_W-1:0]          i_queue_number,
    input  logic signed [mqsb_pkg::DATA_W-1:0]   i_write_data,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [mqsb_pkg::STAT_W-1:0]          o_status,
    output logic signed [mqsb_pkg::DATA_W-1:0]   o_read_data
);
    import mqsb_pkg::*;

    t_cmd w_cmd;
    logic w_out_free;

    // Sequencer
    mqsb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (w_out_free),
        .o_ready    (o_ready),
        .o_cmd      (w_cmd)
    );

    // Queue stores, free list and result register
    mqsb_dpath #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_op           (i_op),
        .i_queue_number (i_queue_number),
        .i_write_data   (i_write_data),
        .i_ready        (i_ready),
        .o_out_free     (w_out_free),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_read_data    (o_read_data)
    );

endmodule

FILE: rtl/mqsb_chk.sv
`timescale 1ns / 1ps

module mqsb_chk (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_ready,
    input logic                               i_op,
    input logic [mqsb_pkg::QNUM_W-1:0]        i_queue_number,
    input logic signed [mqsb_pkg::DATA_W-1:0] i_write_data,
    input logic                               o_valid,
    input logic                               i_ready,
    input logic [mqsb_pkg::STAT_W-1:0]        o_status,
    input logic signed [mqsb_pkg::DATA_W-1:0] o_read_data
);
    import mqsb_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_read_data))
        else $error("result changed while stalled");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK) || (o_status == ST_FULL) || (o_status == ST_EMPTY))
        else $error("undefined status code");

    // An empty result carries all ones
    a_empty_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_EMPTY) |-> (o_read_data == -32'sd1))
        else $error("empty result without all-ones data");

    // A full result carries zero
    a_full_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ST_FULL) |-> (o_read_data == 32'sd0))
        else $error("full result with nonzero data");

    // One item in flight: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second item accepted while one is in flight");

endmodule

bind multi_queue_shared_buffer mqsb_chk u_mqsb_chk (.*);
